// ===== sv/battery_pack_monitor_macros.svh =====
// Assertion macros shared by the battery pack monitor RTL
`ifndef BATTERY_PACK_MONITOR_MACROS_SVH
`define BATTERY_PACK_MONITOR_MACROS_SVH

// Same-cycle implication, checked outside reset
`define BPM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset
`define BPM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

// ===== sv/bpm_pkg.sv =====
// Types, constants and filter arithmetic for the battery pack monitor
package bpm_pkg;

    localparam int unsigned CFG_IDX_W  = 3;
    localparam int unsigned CFG_DATA_W = 32;
    localparam int unsigned IN_DATA_W  = 56;
    localparam int unsigned OUT_DATA_W = 72;
    localparam int unsigned SUM_W      = 24;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_CELL_LOW_LIMIT = 3'd0,
        CFG_PACK_LOW_LIMIT = 3'd1,
        CFG_BEAT_LIMIT     = 3'd2,
        CFG_VOLTAGE_ALPHA  = 3'd3,
        CFG_TEMP_ALPHA     = 3'd4
    } t_cfg_idx;

    localparam logic [15:0]      VOLT_MIN_INIT = 16'hFFFF;
    localparam logic [15:0]      TEMP_MAX_INIT = 16'h8000;
    localparam logic [SUM_W-1:0] SUM_MAX       = {SUM_W{1'b1}};
    localparam logic [31:0]      BEAT_LIMIT_INIT = 32'hFFFF_FFFF;

    typedef struct packed {
        logic [15:0] frame_max_temp;
        logic [15:0] frame_min_volt_mv;
        logic [15:0] filt_max_temp;
        logic [15:0] filt_min_volt_mv;
        logic        volts_ok;
        logic        beat_ok;
        logic        ams_ok;
    } t_result;

    // Q0.16 blend old*a + fresh*(1-a), rounded half up; one 17x17 multiply
    function automatic logic [15:0] blend_q16(input logic [15:0] old_v,
                                              input logic [15:0] fresh_v,
                                              input logic [15:0] alpha);
        logic signed [16:0] diff;
        logic signed [33:0] prod;
        logic signed [33:0] acc;
        diff = $signed({1'b0, old_v}) - $signed({1'b0, fresh_v});
        prod = diff * $signed({1'b0, alpha});
        acc  = prod + $signed({2'b00, fresh_v, 16'h0000}) + 34'sd32768;
        return acc[31:16];
    endfunction

endpackage

// ===== sv/battery_pack_monitor.sv =====
// Battery pack monitor: per-frame cell voltage/temperature checks and filters
//
// Slave stream: one cell sample per beat. tuser is the kind (0 voltage,
// 1 temperature), tdata holds the sample and the frame timestamp, tlast
// closes the frame. Master stream: one result beat per closed frame.
// Config channel: register index and data, always ready, write only while idle.
// Each sample is folded into the running frame state in the cycle it is
// accepted; at a tlast beat the two EMA filters (one 17x17 multiply each)
// and the heartbeat check are evaluated in that same cycle, and the result
// is registered in the result register, or in the skid register while a result waits.
// Throughput: one sample per cycle while s_axis_tready is high. The result register is backed by a
// skid register, so the slave side stays ready while one result waits;
// it deasserts only once both are full and the receiver is still stalled.
// Reset: frame state cleared, filters and last timestamp zero, beat limit
// all ones, other limits and alphas zero, no result pending.
module battery_pack_monitor (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          s_axis_tvalid,
    output logic                          s_axis_tready,
    // [16:0] sample_value, [48:17] time_us, [55:49] zero
    input  logic [bpm_pkg::IN_DATA_W-1:0] s_axis_tdata,
    // [0] mode
    input  logic                          s_axis_tuser,
    input  logic                          s_axis_tlast,
    output logic                          m_axis_tvalid,
    input  logic                          m_axis_tready,
    // [0] ams_ok, [1] beat_ok, [2] volts_ok, [18:3] filt_min_volt_mv,
    // [34:19] filt_max_temp, [50:35] frame_min_volt_mv,
    // [66:51] frame_max_temp, [71:67] zero
    output logic [bpm_pkg::OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [bpm_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [bpm_pkg::CFG_DATA_W-1:0] i_cfg_data
);
    import bpm_pkg::*;
    `include "battery_pack_monitor_macros.svh"

    logic [15:0]      r_cell_low_limit;
    logic [SUM_W-1:0] r_pack_low_limit;
    logic [31:0]      r_beat_limit;
    logic [15:0]      r_volt_alpha;
    logic [15:0]      r_temp_alpha;

    logic [15:0]      r_min_volt, n_min_volt;
    logic [15:0]      r_max_temp, n_max_temp;
    logic [SUM_W-1:0] r_volt_sum, n_volt_sum;
    logic             r_cell_low, n_cell_low;
    logic             r_saw_volt, n_saw_volt;
    logic             r_saw_temp, n_saw_temp;
    logic [15:0]      r_filt_volt, n_filt_volt;
    logic [15:0]      r_filt_temp, n_filt_temp;
    logic [31:0]      r_last_time;

    logic             r_out_v, r_skid_v;
    t_result          r_out, r_skid, n_res;

    logic             in_beat, out_beat, frame_end;
    logic signed [16:0] sample;
    logic [31:0]      time_us;
    logic [15:0]      volt_v;
    logic [16:0]      temp_t;
    logic [SUM_W:0]   sum_ext;
    logic [31:0]      gap;
    logic             beat_ok, volts_ok;

    assign s_axis_tready = !r_skid_v;
    assign o_cfg_ready   = 1'b1;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign out_beat      = r_out_v && m_axis_tready;
    assign frame_end     = in_beat && s_axis_tlast;
    assign m_axis_tvalid = r_out_v;
    assign m_axis_tdata  = {{(OUT_DATA_W - $bits(t_result)){1'b0}}, r_out};

    assign sample  = $signed(s_axis_tdata[16:0]);
    assign time_us = s_axis_tdata[48:17];

    // sample folding into the running frame state
    always_comb begin
        volt_v = sample[16] ? 16'h0000 : sample[15:0];
        temp_t = (!sample[16] && sample[15]) ? 17'h07FFF : sample;
        sum_ext = {1'b0, r_volt_sum} + {{(SUM_W - 15){1'b0}}, volt_v};

        n_min_volt = r_min_volt;
        n_max_temp = r_max_temp;
        n_volt_sum = r_volt_sum;
        n_cell_low = r_cell_low;
        n_saw_volt = r_saw_volt;
        n_saw_temp = r_saw_temp;
        if (!s_axis_tuser) begin
            if (volt_v < r_min_volt) begin
                n_min_volt = volt_v;
            end
            n_volt_sum = sum_ext[SUM_W] ? SUM_MAX : sum_ext[SUM_W-1:0];
            if (volt_v < r_cell_low_limit) begin
                n_cell_low = 1'b1;
            end
            n_saw_volt = 1'b1;
        end else begin
            if ($signed(temp_t) > $signed(r_max_temp)) begin
                n_max_temp = temp_t[15:0];
            end
            n_saw_temp = 1'b1;
        end
    end

    // frame close: filters, heartbeat and pack checks
    always_comb begin
        n_filt_volt = n_saw_volt ? blend_q16(r_filt_volt, n_min_volt, r_volt_alpha)
                                 : r_filt_volt;
        // temperature blended in offset binary: flipping the sign bit adds 32768
        n_filt_temp = n_saw_temp
                    ? (blend_q16({~r_filt_temp[15], r_filt_temp[14:0]},
                                 {~n_max_temp[15], n_max_temp[14:0]},
                                 r_temp_alpha) ^ 16'h8000)
                    : r_filt_temp;
        gap      = time_us - r_last_time;
        beat_ok  = gap <= r_beat_limit;
        volts_ok = !n_cell_low && (n_volt_sum >= r_pack_low_limit);

        n_res.ams_ok            = beat_ok && volts_ok;
        n_res.beat_ok           = beat_ok;
        n_res.volts_ok          = volts_ok;
        n_res.filt_min_volt_mv  = n_filt_volt;
        n_res.filt_max_temp     = n_filt_temp;
        n_res.frame_min_volt_mv = n_min_volt;
        n_res.frame_max_temp    = n_max_temp;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cell_low_limit <= '0;
            r_pack_low_limit <= '0;
            r_beat_limit     <= BEAT_LIMIT_INIT;
            r_volt_alpha     <= '0;
            r_temp_alpha     <= '0;
        end else if (i_cfg_valid) begin
            case (i_cfg_index)
                CFG_CELL_LOW_LIMIT: r_cell_low_limit <= i_cfg_data[15:0];
                CFG_PACK_LOW_LIMIT: r_pack_low_limit <= i_cfg_data[SUM_W-1:0];
                CFG_BEAT_LIMIT:     r_beat_limit     <= i_cfg_data;
                CFG_VOLTAGE_ALPHA:  r_volt_alpha     <= i_cfg_data[15:0];
                CFG_TEMP_ALPHA:     r_temp_alpha     <= i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_min_volt  <= VOLT_MIN_INIT;
            r_max_temp  <= TEMP_MAX_INIT;
            r_volt_sum  <= '0;
            r_cell_low  <= 1'b0;
            r_saw_volt  <= 1'b0;
            r_saw_temp  <= 1'b0;
            r_filt_volt <= '0;
            r_filt_temp <= '0;
            r_last_time <= '0;
        end else if (frame_end) begin
            r_min_volt  <= VOLT_MIN_INIT;
            r_max_temp  <= TEMP_MAX_INIT;
            r_volt_sum  <= '0;
            r_cell_low  <= 1'b0;
            r_saw_volt  <= 1'b0;
            r_saw_temp  <= 1'b0;
            r_filt_volt <= n_filt_volt;
            r_filt_temp <= n_filt_temp;
            r_last_time <= time_us;
        end else if (in_beat) begin
            r_min_volt  <= n_min_volt;
            r_max_temp  <= n_max_temp;
            r_volt_sum  <= n_volt_sum;
            r_cell_low  <= n_cell_low;
            r_saw_volt  <= n_saw_volt;
            r_saw_temp  <= n_saw_temp;
        end
    end

    // result register with skid stage
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_v  <= 1'b0;
            r_skid_v <= 1'b0;
        end else if (r_skid_v) begin
            if (out_beat) begin
                r_out_v  <= 1'b1;
                r_skid_v <= 1'b0;
            end
        end else if (!r_out_v || out_beat) begin
            r_out_v <= frame_end;
        end else if (frame_end) begin
            r_skid_v <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_skid_v) begin
            if (out_beat) begin
                r_out <= r_skid;
            end
        end else if (!r_out_v || out_beat) begin
            if (frame_end) begin
                r_out <= n_res;
            end
        end else if (frame_end) begin
            r_skid <= n_res;
        end
    end

    `BPM_ASSERT_NOW(a_skid_implies_out, r_skid_v, r_out_v, "skid full with output empty")
    `BPM_ASSERT_NEXT(a_mid_frame_filters_hold, in_beat && !s_axis_tlast,
        $stable(r_filt_volt) && $stable(r_filt_temp), "filter moved mid-frame")
    `BPM_ASSERT_NEXT(a_frame_end_clears, frame_end,
        !r_saw_volt && !r_saw_temp && !r_cell_low && r_volt_sum == '0,
        "frame state not cleared at frame end")
    `BPM_ASSERT_NOW(a_result_from_last, $rose(r_out_v),
        $past(frame_end), "result without a closing beat")

endmodule

// ===== test/tb_battery_pack_monitor.sv =====
// Self-checking testbench for battery_pack_monitor: directed table, saturating-sum frames, then randomised frames
`timescale 1ns / 100ps

module tb_battery_pack_monitor;
    import bpm_pkg::*;

    localparam bit          SAMPLE_VOLT  = 1'b0;
    localparam bit          SAMPLE_TEMP  = 1'b1;
    localparam logic [2:0]  CFG_IDX_VOID = 3'd7;
    localparam int          DIR_A        = 6;
    localparam int          DIR_N        = 16;
    localparam int          RAND_PHASES  = 6;
    localparam int          PHASE_ITEMS  = 120;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n = 1'b0;
    logic                   s_axis_tvalid = 1'b0;
    logic                   s_axis_tready;
    logic [IN_DATA_W-1:0]   s_axis_tdata = '0;
    logic                   s_axis_tuser = 1'b0;
    logic                   s_axis_tlast = 1'b0;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready = 1'b0;
    logic [OUT_DATA_W-1:0]  m_axis_tdata;
    logic                   i_cfg_valid = 1'b0;
    logic                   o_cfg_ready;
    logic [CFG_IDX_W-1:0]   i_cfg_index = '0;
    logic [CFG_DATA_W-1:0]  i_cfg_data = '0;

    battery_pack_monitor u_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    // shadow of the block's registers and frame state
    logic [15:0]        lim_cell = 16'h0000;
    logic [23:0]        lim_pack = 24'h000000;
    logic [31:0]        lim_beat = 32'hFFFF_FFFF;
    logic [15:0]        a_volt = 16'h0000;
    logic [15:0]        a_temp = 16'h0000;
    logic [15:0]        lo_volt = 16'hFFFF;
    logic signed [15:0] hi_temp = 16'sh8000;
    logic [23:0]        volt_sum = 24'h000000;
    bit                 low_cell = 1'b0;
    bit                 got_volt = 1'b0;
    bit                 got_temp = 1'b0;
    logic [15:0]        ema_volt = 16'h0000;
    logic [15:0]        ema_temp = 16'h0000;
    logic [31:0]        prev_stamp = 32'h0000_0000;

    t_result    pending_frames[$];
    bit         steady = 1'b0;
    int         mismatches = 0;
    int         frames_checked = 0;
    int         samples_sent = 0;
    int         settings_used = 1;
    logic [31:0] stamp_now = 32'h0000_0000;

    typedef struct {
        bit          kind;
        logic [16:0] val;
        bit          lst;
        logic [31:0] stamp;
        bit          typed;
        t_result     want;
    } t_cell_row;

    t_cell_row dir_rows [DIR_N];

    function automatic logic [15:0] q16_mix(input logic [15:0] old_v,
                                            input logic [15:0] fresh_v,
                                            input logic [15:0] alpha);
        logic [47:0] acc;
        acc = 48'(old_v) * 48'(alpha) + 48'(fresh_v) * (48'h10000 - 48'(alpha))
            + 48'd32768;
        return acc[31:16];
    endfunction

    // fold one accepted sample in; returns 1 when it closes a frame
    function automatic bit fold_sample(input bit kind, input logic [16:0] val,
                                       input bit lst, input logic [31:0] stamp,
                                       output t_result res);
        logic [15:0]        v;
        logic signed [15:0] t;
        logic [24:0]        s;
        logic [31:0]        gap;
        bit                 beat_good;
        bit                 volt_good;
        res = '0;
        if (kind == SAMPLE_VOLT) begin
            v = val[16] ? 16'h0000 : val[15:0];
            if (v < lo_volt) lo_volt = v;
            s = {1'b0, volt_sum} + 25'(v);
            volt_sum = s[24] ? 24'hFFFFFF : s[23:0];
            if (v < lim_cell) low_cell = 1'b1;
            got_volt = 1'b1;
        end else begin
            // below -32768 can never beat the running max, so clamping is harmless
            t = (val[16] == val[15]) ? val[15:0] : (val[16] ? 16'h8000 : 16'h7FFF);
            if (t > hi_temp) hi_temp = t;
            got_temp = 1'b1;
        end
        if (!lst) return 1'b0;
        if (got_volt) ema_volt = q16_mix(ema_volt, lo_volt, a_volt);
        if (got_temp) ema_temp = q16_mix(ema_temp ^ 16'h8000, hi_temp ^ 16'h8000, a_temp)
                                 ^ 16'h8000;
        gap        = stamp - prev_stamp;
        beat_good  = (gap <= lim_beat);
        volt_good  = !low_cell && (volt_sum >= lim_pack);
        prev_stamp = stamp;
        res.ams_ok            = beat_good && volt_good;
        res.beat_ok           = beat_good;
        res.volts_ok          = volt_good;
        res.filt_min_volt_mv  = ema_volt;
        res.filt_max_temp     = ema_temp;
        res.frame_min_volt_mv = lo_volt;
        res.frame_max_temp    = hi_temp;
        lo_volt  = 16'hFFFF;
        hi_temp  = 16'sh8000;
        volt_sum = '0;
        low_cell = 1'b0;
        got_volt = 1'b0;
        got_temp = 1'b0;
        return 1'b1;
    endfunction

    task automatic flag_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
        $display("[%0t] mismatch on %s: got %0h, expected %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic check_frame(input t_result got, input t_result want);
        if (got.ams_ok !== want.ams_ok)
            flag_mismatch("ams_ok", 32'(got.ams_ok), 32'(want.ams_ok));
        if (got.beat_ok !== want.beat_ok)
            flag_mismatch("beat_ok", 32'(got.beat_ok), 32'(want.beat_ok));
        if (got.volts_ok !== want.volts_ok)
            flag_mismatch("volts_ok", 32'(got.volts_ok), 32'(want.volts_ok));
        if (got.filt_min_volt_mv !== want.filt_min_volt_mv)
            flag_mismatch("filt_min_volt_mv", 32'(got.filt_min_volt_mv),
                          32'(want.filt_min_volt_mv));
        if (got.filt_max_temp !== want.filt_max_temp)
            flag_mismatch("filt_max_temp", 32'(got.filt_max_temp),
                          32'(want.filt_max_temp));
        if (got.frame_min_volt_mv !== want.frame_min_volt_mv)
            flag_mismatch("frame_min_volt_mv", 32'(got.frame_min_volt_mv),
                          32'(want.frame_min_volt_mv));
        if (got.frame_max_temp !== want.frame_max_temp)
            flag_mismatch("frame_max_temp", 32'(got.frame_max_temp),
                          32'(want.frame_max_temp));
        frames_checked++;
    endtask

    always @(posedge i_clk) m_axis_tready <= steady || ($urandom_range(0, 99) >= 10);

    always @(posedge i_clk) begin
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (pending_frames.size() == 0)
                flag_mismatch("result beat with nothing pending", 32'h0, 32'h0);
            else
                check_frame(t_result'(m_axis_tdata[$bits(t_result)-1:0]),
                            pending_frames.pop_front());
        end
    end

    task automatic write_reg(input logic [2:0] idx, input logic [31:0] data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        case (idx)
            CFG_CELL_LOW_LIMIT: lim_cell = data[15:0];
            CFG_PACK_LOW_LIMIT: lim_pack = data[23:0];
            CFG_BEAT_LIMIT:     lim_beat = data;
            CFG_VOLTAGE_ALPHA:  a_volt   = data[15:0];
            CFG_TEMP_ALPHA:     a_temp   = data[15:0];
            default: ;
        endcase
    endtask

    task automatic push_beat(input bit kind, input logic [16:0] val, input bit lst,
                             input logic [31:0] stamp, input bit typed,
                             input t_result want);
        t_result res;
        while (!steady && $urandom_range(0, 99) < 10) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tlast  <= lst;
        s_axis_tdata  <= {7'b0, stamp, val};
        do @(posedge i_clk); while (!s_axis_tready);
        samples_sent++;
        if (fold_sample(kind, val, lst, stamp, res))
            pending_frames.push_back(typed ? want : res);
    endtask

    // hold the sender off until every frame result is back, then let the block go quiet
    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (pending_frames.size() != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    task automatic apply_setting(input int ph);
        logic [15:0] va;
        logic [15:0] ta;
        logic [15:0] cl;
        logic [23:0] pl;
        logic [31:0] bl;
        case (ph)
            0: begin
                va = 16'hFFFF; ta = 16'h0000; cl = 16'h0000; pl = 24'h000000; bl = 32'h0;
            end
            1: begin
                va = 16'h0000; ta = 16'hFFFF; cl = 16'hFFFF; pl = 24'hFFFFFF;
                bl = 32'hFFFF_FFFF;
            end
            default: begin
                va = 16'($urandom);
                ta = 16'($urandom);
                cl = 16'($urandom_range(2400, 3400));
                pl = 24'($urandom_range(0, 20000));
                bl = $urandom_range(0, 1500);
            end
        endcase
        // junk above each register's width must be dropped
        write_reg(CFG_CELL_LOW_LIMIT, {16'($urandom), cl});
        write_reg(CFG_PACK_LOW_LIMIT, {8'($urandom), pl});
        write_reg(CFG_BEAT_LIMIT, bl);
        write_reg(CFG_VOLTAGE_ALPHA, {16'($urandom), va});
        write_reg(CFG_TEMP_ALPHA, {16'($urandom), ta});
        if (ph == 0) write_reg(CFG_IDX_VOID, $urandom);
        settings_used++;
    endtask

    task automatic send_random_frame();
        int          len;
        int          style;
        bit          kind;
        logic [16:0] val;
        logic [31:0] gap;
        len   = ($urandom_range(0, 19) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
        style = $urandom_range(0, 9);
        case ($urandom_range(0, 9))
            0:       gap = lim_beat;
            1:       gap = lim_beat + 32'd1;
            2:       gap = $urandom;
            default: gap = $urandom_range(0, 1500);
        endcase
        stamp_now += gap;
        for (int i = 0; i < len; i++) begin
            if (style == 0)      kind = SAMPLE_VOLT;
            else if (style == 1) kind = SAMPLE_TEMP;
            else                 kind = 1'($urandom_range(0, 1));
            case ($urandom_range(0, 9))
                0: val = 17'($urandom);
                1: begin
                    case ($urandom_range(0, 6))
                        0:       val = 17'h00000;
                        1:       val = 17'h0FFFF;
                        2:       val = 17'h1FFFF;
                        3:       val = 17'h10000;
                        4:       val = 17'h07FFF;
                        5:       val = 17'h08000;
                        default: val = 17'h18000;
                    endcase
                end
                default: begin
                    if (kind == SAMPLE_VOLT) val = 17'($urandom_range(2400, 4300));
                    else                     val = 17'($urandom_range(0, 1300)) - 17'd400;
                end
            endcase
            push_beat(kind, val, i == len - 1, (i == len - 1) ? stamp_now : $urandom,
                      1'b0, '0);
        end
    endtask

    initial begin
        // result fields, high to low: frame_max_temp, frame_min_volt_mv, filt_max_temp,
        // filt_min_volt_mv, volts_ok, beat_ok, ams_ok
        dir_rows = '{
            // reset settings: alphas zero so filters follow the frame at once
            '{SAMPLE_VOLT, 17'h00000,    1'b0, 32'hAAAA_5555, 1'b0, '0},
            '{SAMPLE_VOLT, 17'h0FFFF,    1'b0, 32'h5555_AAAA, 1'b0, '0},
            '{SAMPLE_TEMP, -17'sd32768,  1'b0, 32'hFFFF_0000, 1'b0, '0},
            '{SAMPLE_TEMP, 17'h0FFFF,    1'b1, 32'h0000_0000, 1'b1,
              {16'h7FFF, 16'h0000, 16'h7FFF, 16'h0000, 3'b111}},
            // negative voltage reads as zero; no temperatures, so that filter holds
            '{SAMPLE_VOLT, -17'sd1,      1'b1, 32'hFFFF_FFFF, 1'b1,
              {16'h8000, 16'h0000, 16'h7FFF, 16'h0000, 3'b111}},
            // temperatures only, gap wraps past zero
            '{SAMPLE_TEMP, -17'sd32768,  1'b1, 32'h0000_0005, 1'b1,
              {16'h8000, 16'hFFFF, 16'h8000, 16'h0000, 3'b111}},
            // limits set, alphas at full scale
            '{SAMPLE_VOLT, 17'd3000,     1'b0, 32'h0F0F_0F0F, 1'b0, '0},
            '{SAMPLE_VOLT, 17'd3500,     1'b0, 32'hF0F0_F0F0, 1'b0, '0},
            '{SAMPLE_VOLT, 17'd4200,     1'b1, 32'd505,       1'b0, '0},
            '{SAMPLE_VOLT, 17'd2999,     1'b1, 32'd1506,      1'b0, '0},
            '{SAMPLE_TEMP, 17'd600,      1'b0, 32'h1234_5678, 1'b0, '0},
            '{SAMPLE_TEMP, -17'sd400,    1'b0, 32'h8765_4321, 1'b0, '0},
            '{SAMPLE_TEMP, 17'h07FFF,    1'b1, 32'd2506,      1'b0, '0},
            '{SAMPLE_VOLT, 17'h0FFFF,    1'b0, 32'hDEAD_BEEF, 1'b0, '0},
            '{SAMPLE_TEMP, 17'h10000,    1'b1, 32'd2506,      1'b0, '0},
            '{SAMPLE_VOLT, 17'h10000,    1'b1, 32'd1,         1'b0, '0}
        };

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < DIR_N; r++) begin
            if (r == DIR_A) begin
                settle();
                write_reg(CFG_CELL_LOW_LIMIT, 32'd3000);
                write_reg(CFG_PACK_LOW_LIMIT, 32'd10000);
                write_reg(CFG_BEAT_LIMIT, 32'd1000);
                write_reg(CFG_VOLTAGE_ALPHA, 32'h0000_FFFF);
                write_reg(CFG_TEMP_ALPHA, 32'h0000_FFFF);
                settings_used++;
            end
            push_beat(dir_rows[r].kind, dir_rows[r].val, dir_rows[r].lst,
                      dir_rows[r].stamp, dir_rows[r].typed, dir_rows[r].want);
        end
        settle();
        stamp_now = prev_stamp;

        // long frames of full-scale cells: the sum has to saturate to meet the limit
        write_reg(CFG_CELL_LOW_LIMIT, 32'd0);
        write_reg(CFG_PACK_LOW_LIMIT, 32'h00FF_FFFF);
        write_reg(CFG_BEAT_LIMIT, 32'hFFFF_FFFF);
        settings_used++;
        for (int f = 0; f < 2; f++) begin
            stamp_now += 32'd10;
            for (int i = 0; i < 260 - 4 * f; i++)
                push_beat(SAMPLE_VOLT, 17'h0FFFF, i == 259 - 4 * f,
                          (i == 259 - 4 * f) ? stamp_now : $urandom, 1'b0, '0);
        end
        settle();

        for (int ph = 0; ph < RAND_PHASES; ph++) begin
            int phase_goal;
            apply_setting(ph);
            steady = (ph == 2);
            phase_goal = samples_sent + PHASE_ITEMS;
            while (samples_sent < phase_goal) send_random_frame();
            settle();
            steady = 1'b0;
        end

        $display("run covered %0d samples in %0d checked frames across %0d register settings",
                 samples_sent, frames_checked, settings_used);
        $display("field mismatches: %0d", mismatches);
        if (mismatches == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial begin
        #2_000_000;
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule

// ===== battery_pack_monitor.f =====
+incdir+sv
sv/bpm_pkg.sv
sv/battery_pack_monitor.sv
test/tb_battery_pack_monitor.sv
